@@ sv/bba_pkg.sv @@
// shared types and constants of the buddy block allocator
package bba_pkg;

    localparam int POOL_POWER_DEF       = 16;
    localparam int LEAF_FLOOR_POWER_DEF = 6;

    localparam logic [4:0] MIN_POWER_RESET = 5'd6;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef logic [1:0] t_kind;

    localparam t_kind K_ABSENT = 2'd0;
    localparam t_kind K_SPLIT  = 2'd1;
    localparam t_kind K_FREE   = 2'd2;
    localparam t_kind K_USED   = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [16:0] request_size;
        logic [15:0] block_offset;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [15:0] granted_offset;
    } t_rsp;

endpackage

@@ sv/bba_ram.sv @@
// generic simple dual-port ram with registered read
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/bba_target.sv @@
// block power of an allocate request and whether it fits the pool
module bba_target #(
    parameter int POOL_POWER = 16,
    parameter int FLOOR_P    = 6
) (
    input  logic [16:0] i_size,
    input  logic [4:0]  i_min_power,
    output logic [5:0]  o_target,
    output logic        o_fit
);
    logic [16:0] size_m1;
    logic [4:0]  ceil_p;
    logic [5:0]  t0;
    logic [5:0]  t1;

    always_comb begin
        size_m1 = i_size - 17'd1;
        ceil_p  = 5'd0;
        if (i_size > 17'd1) begin
            for (int i = 0; i < 17; i++) begin
                if (size_m1[i]) begin
                    ceil_p = 5'(i + 1);
                end
            end
        end
        t0 = ({1'b0, ceil_p} < {1'b0, i_min_power}) ? {1'b0, i_min_power} : {1'b0, ceil_p};
        t1 = (t0 < 6'(FLOOR_P)) ? 6'(FLOOR_P) : t0;
        o_target = t1;
        o_fit    = (t1 <= 6'(POOL_POWER));
    end
endmodule

@@ sv/buddy_block_allocator.sv @@
// buddy block allocator top level: request sequencer over the node-kind memory
//
// After reset the block clears its node memory, one node a cycle, through all
// 2^(levels)-1 nodes (2047 at the default pool of 64 KiB with 64-byte leaves),
// and stalls input meanwhile. Each request then works on the single node
// memory: an allocate scans tree nodes (a read and a check state each) from
// the target level upward until it finds a free block, then splits it down
// level by level; a free walks down the tree (a read and a check state per
// level), then merges upward, reading both buddies and writing them and their parent.
// One request is in flight at a time; a result register lets the next request
// enter while the previous result waits to be taken.
module buddy_block_allocator #(
    parameter int POOL_POWER       = bba_pkg::POOL_POWER_DEF,
    parameter int LEAF_FLOOR_POWER = bba_pkg::LEAF_FLOOR_POWER_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bba_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bba_pkg::t_rsp o_out_data,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata
);
    import bba_pkg::*;

    localparam int LEVELS  = ((POOL_POWER > LEAF_FLOOR_POWER) ?
                              POOL_POWER - LEAF_FLOOR_POWER : 0) + 1;
    localparam int FLOOR_P = POOL_POWER - (LEVELS - 1);
    localparam int NODES   = (1 << LEVELS) - 1;
    localparam int NW      = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PIW     = $clog2(POOL_POWER);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CK  = 4'd3;
    localparam logic [3:0] S_A_SPL = 4'd4;
    localparam logic [3:0] S_A_SPR = 4'd5;
    localparam logic [3:0] S_A_USE = 4'd6;
    localparam logic [3:0] S_F_RD  = 4'd7;
    localparam logic [3:0] S_F_CK  = 4'd8;
    localparam logic [3:0] S_M_RL  = 4'd9;
    localparam logic [3:0] S_M_RR  = 4'd10;
    localparam logic [3:0] S_M_CK  = 4'd11;
    localparam logic [3:0] S_M_WL  = 4'd12;
    localparam logic [3:0] S_M_WR  = 4'd13;
    localparam logic [3:0] S_M_WP  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    function automatic logic [NW-1:0] first_of(input logic [5:0] d);
        first_of = ~({NW{1'b1}} << d);
    endfunction

    logic [3:0]            r_state, n_state;
    logic [4:0]            r_minp;
    logic [NW-1:0]         r_node, n_node;
    logic [NW-1:0]         r_j, n_j;
    logic [5:0]            r_p, n_p;
    logic [5:0]            r_d, n_d;
    logic [5:0]            r_t, n_t;
    logic [POOL_POWER-1:0] r_foff, n_foff;
    logic [POOL_POWER-1:0] r_goff, n_goff;
    logic                  r_st, n_st;
    t_kind                 r_lk, n_lk;
    logic                  r_ov, n_ov;
    t_rsp                  r_out, n_out;

    logic          we;
    logic [NW-1:0] waddr;
    t_kind         wdata;
    logic [NW-1:0] raddr;
    t_kind         rdata;

    logic [5:0]    tgt;
    logic          fit;
    logic          accept;
    logic          ovf;
    logic [NW-1:0] left_c;
    logic [NW-1:0] right_c;
    logic [NW-1:0] lft;
    logic [NW-1:0] parent;
    logic [31:0]   off_w;
    logic          dir_bit;

    bba_target #(.POOL_POWER(POOL_POWER), .FLOOR_P(FLOOR_P)) u_target (
        .i_size      (i_in_data.request_size),
        .i_min_power (r_minp),
        .o_target    (tgt),
        .o_fit       (fit)
    );

    bba_ram #(.WIDTH(2), .DEPTH(NODES), .AW(NW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign ovf     = ((32'(i_in_data.block_offset) >> POOL_POWER) != 32'd0);
    assign left_c  = NW'(r_node << 1) + NW'(1);
    assign right_c = NW'(r_node << 1) + NW'(2);
    assign lft     = r_node - NW'(!r_node[0]);
    assign parent  = NW'((r_node - NW'(1)) >> 1);
    assign off_w   = 32'(r_j) << r_p;
    assign dir_bit = r_foff[PIW'(r_p - 6'd1)];

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_j     = r_j;
        n_p     = r_p;
        n_d     = r_d;
        n_t     = r_t;
        n_foff  = r_foff;
        n_goff  = r_goff;
        n_st    = r_st;
        n_lk    = r_lk;
        n_ov    = r_ov;
        n_out   = r_out;
        we      = 1'b0;
        waddr   = r_node;
        wdata   = K_ABSENT;
        raddr   = r_node;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                wdata = (r_node == '0) ? K_FREE : K_ABSENT;
                if (r_node == NW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_node = r_node + NW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_st   = STATUS_OK;
                    n_goff = '0;
                    if (i_in_data.mode == MODE_ALLOC) begin
                        if (!fit) begin
                            n_st    = STATUS_OOM;
                            n_state = S_DONE;
                        end else begin
                            n_t     = tgt;
                            n_p     = tgt;
                            n_d     = 6'(POOL_POWER) - tgt;
                            n_j     = '0;
                            n_node  = first_of(6'(POOL_POWER) - tgt);
                            n_state = S_A_RD;
                        end
                    end else begin
                        n_foff = POOL_POWER'(i_in_data.block_offset);
                        if (ovf) begin
                            n_state = S_DONE;
                        end else begin
                            n_node  = '0;
                            n_p     = 6'(POOL_POWER);
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_CK;
            end
            S_A_CK: begin
                if (rdata == K_FREE) begin
                    n_goff  = POOL_POWER'(off_w);
                    n_state = (r_p > r_t) ? S_A_SPL : S_A_USE;
                end else if (r_j == first_of(r_d)) begin
                    if (r_d == 6'd0) begin
                        n_st    = STATUS_OOM;
                        n_state = S_DONE;
                    end else begin
                        n_d     = r_d - 6'd1;
                        n_p     = r_p + 6'd1;
                        n_j     = '0;
                        n_node  = first_of(r_d - 6'd1);
                        n_state = S_A_RD;
                    end
                end else begin
                    n_j     = r_j + NW'(1);
                    n_node  = r_node + NW'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_SPL: begin
                we      = 1'b1;
                wdata   = K_SPLIT;
                n_state = S_A_SPR;
            end
            S_A_SPR: begin
                we      = 1'b1;
                waddr   = right_c;
                wdata   = K_FREE;
                n_node  = left_c;
                n_p     = r_p - 6'd1;
                n_state = ((r_p - 6'd1) > r_t) ? S_A_SPL : S_A_USE;
            end
            S_A_USE: begin
                we      = 1'b1;
                wdata   = K_USED;
                n_state = S_DONE;
            end
            S_F_RD: begin
                n_state = S_F_CK;
            end
            S_F_CK: begin
                if (rdata == K_SPLIT && r_p > 6'(FLOOR_P)) begin
                    n_node  = dir_bit ? right_c : left_c;
                    n_p     = r_p - 6'd1;
                    n_state = S_F_RD;
                end else if (rdata == K_USED || rdata == K_FREE) begin
                    we      = 1'b1;
                    wdata   = K_FREE;
                    n_state = S_M_RL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_RL: begin
                raddr = lft;
                if (r_node == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_M_RR;
                end
            end
            S_M_RR: begin
                raddr   = lft + NW'(1);
                n_lk    = rdata;
                n_state = S_M_CK;
            end
            S_M_CK: begin
                n_state = (r_lk == K_FREE && rdata == K_FREE) ? S_M_WL : S_DONE;
            end
            S_M_WL: begin
                we      = 1'b1;
                waddr   = lft;
                n_state = S_M_WR;
            end
            S_M_WR: begin
                we      = 1'b1;
                waddr   = lft + NW'(1);
                n_state = S_M_WP;
            end
            S_M_WP: begin
                we      = 1'b1;
                waddr   = parent;
                wdata   = K_FREE;
                n_node  = parent;
                n_state = S_M_RL;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov                 = 1'b1;
                    n_out.status         = r_st;
                    n_out.granted_offset = 16'(r_goff);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_node  <= '0;
            r_ov    <= 1'b0;
            r_minp  <= MIN_POWER_RESET;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_minp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_p    <= n_p;
        r_d    <= n_d;
        r_t    <= n_t;
        r_foff <= n_foff;
        r_goff <= n_goff;
        r_st   <= n_st;
        r_lk   <= n_lk;
        r_out  <= n_out;
    end
endmodule
